// ===== hw/rtl/ftl_pkg.sv =====
package ftl_pkg;

  localparam int SENSOR_COUNT_DEF = 8;
  localparam int SAMPLE_BITS_DEF  = 12;
  localparam int TORQUE_BITS_DEF  = 16;

  localparam int SAFETY_RESET     = 3276;
  localparam int COMPLIANCE_RESET = 409;

  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SAFETY     = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_COMPLIANCE = CFG_INDEX_BITS'(1);

endpackage

// ===== hw/rtl/ftl_if.sv =====
interface ftl_in_if #(
  parameter int SAMPLE_BITS = ftl_pkg::SAMPLE_BITS_DEF,
  parameter int TORQUE_BITS = ftl_pkg::TORQUE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic        [SAMPLE_BITS-1:0] force_0;
  logic        [SAMPLE_BITS-1:0] force_1;
  logic        [SAMPLE_BITS-1:0] force_2;
  logic        [SAMPLE_BITS-1:0] force_3;
  logic        [SAMPLE_BITS-1:0] force_4;
  logic        [SAMPLE_BITS-1:0] force_5;
  logic        [SAMPLE_BITS-1:0] force_6;
  logic        [SAMPLE_BITS-1:0] force_7;
  logic signed [TORQUE_BITS-1:0] torque_command;

  modport source (
    output valid, force_0, force_1, force_2, force_3, force_4, force_5, force_6, force_7,
           torque_command,
    input  ready
  );
  modport sink (
    input  valid, force_0, force_1, force_2, force_3, force_4, force_5, force_6, force_7,
           torque_command,
    output ready
  );
endinterface

interface ftl_out_if #(
  parameter int SAMPLE_BITS = ftl_pkg::SAMPLE_BITS_DEF,
  parameter int TORQUE_BITS = ftl_pkg::TORQUE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [TORQUE_BITS-1:0] torque_out;
  logic                          safety_tripped;
  logic                          compliance_active;
  logic        [SAMPLE_BITS-1:0] peak_force;
  logic        [SAMPLE_BITS-1:0] mean_force;

  modport source (
    output valid, torque_out, safety_tripped, compliance_active, peak_force, mean_force,
    input  ready
  );
  modport sink (
    input  valid, torque_out, safety_tripped, compliance_active, peak_force, mean_force,
    output ready
  );
endinterface

// ===== hw/rtl/ftl_accum.sv =====
module ftl_accum #(
  parameter int SENSOR_COUNT = ftl_pkg::SENSOR_COUNT_DEF,
  parameter int SAMPLE_BITS  = ftl_pkg::SAMPLE_BITS_DEF,
  parameter int CNT_W        = $clog2(SENSOR_COUNT + 1),
  parameter int SUM_W        = SAMPLE_BITS + CNT_W
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [SAMPLE_BITS-1:0] samples [SENSOR_COUNT],
  output logic                   busy,
  output logic [SAMPLE_BITS-1:0] peak,
  output logic [SUM_W-1:0]       sum
);
  import ftl_pkg::*;

  logic [SAMPLE_BITS-1:0] line [SENSOR_COUNT];
  logic [CNT_W-1:0]       cnt;

  assign busy = (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(SENSOR_COUNT);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  // one sample per cycle leaves the head of the shift line
  always_ff @(posedge clk) begin
    if (start) begin
      line <= samples;
      peak <= '0;
      sum  <= '0;
    end else if (busy) begin
      sum <= sum + SUM_W'(line[0]);
      if (line[0] > peak) begin
        peak <= line[0];
      end
      for (int i = 0; i < SENSOR_COUNT - 1; i++) begin
        line[i] <= line[i+1];
      end
    end
  end

endmodule

// ===== hw/rtl/ftl_mul.sv =====
module ftl_mul #(
  parameter int AW = ftl_pkg::TORQUE_BITS_DEF,
  parameter int BW = ftl_pkg::SAMPLE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             busy,
  output logic [AW+BW-1:0] product
);
  import ftl_pkg::*;

  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0] a_r;
  logic [CW-1:0] cnt;
  logic [AW:0]   add;

  assign busy = (cnt != '0);

  // shift-add, multiplier bits consumed LSB first from the low end of product
  assign add = {1'b0, product[AW+BW-1:BW]} + (product[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(BW);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r     <= a;
      product <= {{AW{1'b0}}, b};
    end else if (busy) begin
      product <= {add, product[BW-1:1]};
    end
  end

endmodule

// ===== hw/rtl/ftl_div.sv =====
module ftl_div #(
  parameter int QW = ftl_pkg::TORQUE_BITS_DEF,
  parameter int DW = ftl_pkg::SAMPLE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] hi,
  input  logic [QW-1:0] lo,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [QW-1:0] quotient
);
  import ftl_pkg::*;

  localparam int CW = $clog2(QW + 1);

  // restoring division, one quotient bit per cycle; hi must be below divisor
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  assign busy  = (cnt != '0);
  assign trial = {rem, quotient[QW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(QW);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= hi;
      dvs      <= divisor;
      quotient <= lo;
    end else if (busy) begin
      rem      <= fits ? diff[DW-1:0] : trial[DW-1:0];
      quotient <= {quotient[QW-2:0], fits};
    end
  end

endmodule

// ===== hw/rtl/tactile_force_torque_limiter.sv =====
// Channel   Modport  Transaction
// --------  -------  ---------------------------------------------------------
// frame     sink     force_0..force_7, torque_command
// result    source   torque_out, safety_tripped, compliance_active,
//                    peak_force, mean_force
// cfg_*     write    register index, data; taken on any edge with cfg_write
//
// One frame at a time: a frame passes through the sample scan, the bit-serial
// multiplier (with the mean divider alongside) and the bit-serial divider in
// turn, and the next frame is taken only once the result is loaded into the
// output register.
// Reset (rst, synchronous) restores both thresholds and clears the safety
// latch. A result held by a stalled sink does not block the next frame; only
// a second finished result waits for the output register.
module tactile_force_torque_limiter #(
  parameter int SENSOR_COUNT = ftl_pkg::SENSOR_COUNT_DEF,
  parameter int SAMPLE_BITS  = ftl_pkg::SAMPLE_BITS_DEF,
  parameter int TORQUE_BITS  = ftl_pkg::TORQUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [ftl_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [SAMPLE_BITS-1:0]              cfg_data,
  ftl_in_if.sink                              frame,
  ftl_out_if.source                           result
);
  import ftl_pkg::*;

  localparam int CNT_W = $clog2(SENSOR_COUNT + 1);
  localparam int SUM_W = SAMPLE_BITS + CNT_W;
  localparam int PW    = TORQUE_BITS + SAMPLE_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [SAMPLE_BITS-1:0] safety_thr;
  logic [SAMPLE_BITS-1:0] compliance_thr;
  logic                   latch;

  logic [SAMPLE_BITS-1:0] all_f [8];
  logic [SAMPLE_BITS-1:0] samples [SENSOR_COUNT];

  logic signed [TORQUE_BITS-1:0] cmd;
  logic [SAMPLE_BITS-1:0]        peak_r;
  logic [SAMPLE_BITS-1:0]        span;
  logic                          comp_r;
  logic                          zero_r;
  logic                          pass_r;
  logic                          neg_r;

  logic                   accept;
  logic                   acc_done;
  logic                   mul_done;
  logic                   div_done;
  logic                   load_out;

  logic                   acc_busy;
  logic [SAMPLE_BITS-1:0] acc_peak;
  logic [SUM_W-1:0]       acc_sum;

  logic                   mul_busy;
  logic [TORQUE_BITS-1:0] cmd_mag;
  logic [SAMPLE_BITS-1:0] factor;
  logic [PW-1:0]          product;

  logic                   div_busy;
  logic [TORQUE_BITS-1:0] quo;

  logic                   mean_busy;
  logic [SAMPLE_BITS-1:0] mean_q;

  logic                   over_safety;
  logic                   over_comp;
  logic                   trip;
  logic [TORQUE_BITS-1:0] torque_sel;

  assign all_f[0] = frame.force_0;
  assign all_f[1] = frame.force_1;
  assign all_f[2] = frame.force_2;
  assign all_f[3] = frame.force_3;
  assign all_f[4] = frame.force_4;
  assign all_f[5] = frame.force_5;
  assign all_f[6] = frame.force_6;
  assign all_f[7] = frame.force_7;

  for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_samp
    assign samples[g] = all_f[g];
  end

  assign frame.ready = (state == S_IDLE);
  assign accept      = frame.valid && frame.ready;
  assign acc_done    = (state == S_ACC) && !acc_busy;
  // the mean divider runs as long as the multiplier
  assign mul_done    = (state == S_MUL) && !mul_busy && !mean_busy;
  assign div_done    = (state == S_DIV) && !div_busy;
  assign load_out    = (state == S_FIN) && (!result.valid || result.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_ACC;
      S_ACC:  if (!acc_busy) state_next = S_MUL;
      S_MUL:  if (mul_done) state_next = S_DIV;
      S_DIV:  if (div_done) state_next = S_FIN;
      S_FIN:  if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      safety_thr     <= SAMPLE_BITS'(SAFETY_RESET);
      compliance_thr <= SAMPLE_BITS'(COMPLIANCE_RESET);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SAFETY:     safety_thr     <= cfg_data;
        REG_COMPLIANCE: compliance_thr <= cfg_data;
        default: ;
      endcase
    end
  end

  ftl_accum #(
    .SENSOR_COUNT(SENSOR_COUNT),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W)
  ) u_accum (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .samples(samples),
    .busy   (acc_busy),
    .peak   (acc_peak),
    .sum    (acc_sum)
  );

  // decisions from the frame peak; the latch is set before torque is chosen
  assign over_safety = acc_peak > safety_thr;
  assign over_comp   = acc_peak > compliance_thr;
  assign trip        = latch || over_safety;
  assign cmd_mag     = cmd[TORQUE_BITS-1] ? TORQUE_BITS'(-cmd) : TORQUE_BITS'(cmd);
  // span - excess reduces to safety - peak
  assign factor      = safety_thr - acc_peak;

  always_ff @(posedge clk) begin
    if (rst) begin
      latch <= 1'b0;
    end else if (acc_done) begin
      latch <= trip;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= frame.torque_command;
    end
    if (acc_done) begin
      peak_r <= acc_peak;
      span   <= safety_thr - compliance_thr;
      comp_r <= over_comp;
      pass_r <= !over_comp;
      neg_r  <= cmd[TORQUE_BITS-1];
      zero_r <= trip || (over_comp && ((safety_thr <= compliance_thr) ||
                                       (acc_peak >= safety_thr)));
    end
  end

  ftl_mul #(
    .AW(TORQUE_BITS),
    .BW(SAMPLE_BITS)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (acc_done),
    .a      (cmd_mag),
    .b      (factor),
    .busy   (mul_busy),
    .product(product)
  );

  // mean runs alongside the multiply: sum / SENSOR_COUNT, one bit per cycle
  ftl_div #(
    .QW(SAMPLE_BITS),
    .DW(CNT_W)
  ) u_mean (
    .clk     (clk),
    .rst     (rst),
    .start   (acc_done),
    .hi      (acc_sum[SUM_W-1:SAMPLE_BITS]),
    .lo      (acc_sum[SAMPLE_BITS-1:0]),
    .divisor (CNT_W'(SENSOR_COUNT)),
    .busy    (mean_busy),
    .quotient(mean_q)
  );

  // quotient is below |cmd|, so the top of the product is already below span
  ftl_div #(
    .QW(TORQUE_BITS),
    .DW(SAMPLE_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_done),
    .hi      (product[PW-1:TORQUE_BITS]),
    .lo      (product[TORQUE_BITS-1:0]),
    .divisor (span),
    .busy    (div_busy),
    .quotient(quo)
  );

  always_comb begin
    priority if (zero_r) begin
      torque_sel = '0;
    end else if (pass_r) begin
      torque_sel = TORQUE_BITS'(cmd);
    end else if (neg_r) begin
      torque_sel = -quo;
    end else begin
      torque_sel = quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_out) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.torque_out        <= signed'(torque_sel);
      result.safety_tripped    <= latch;
      result.compliance_active <= comp_r;
      result.peak_force        <= peak_r;
      result.mean_force        <= mean_q;
    end
  end

endmodule
